@@ design/whc_pkg.sv @@
// ----------------------------------------------------------------------------
// whc_pkg
// Shared types, constants and helpers for the WAV header check and sample
// unpacker.
// ----------------------------------------------------------------------------
package whc_pkg;

    localparam int BYTE_W     = 8;
    localparam int RATE_W     = 18;
    localparam int WORD_W     = 32;
    localparam int POS_W      = 6;
    localparam int SAMPLE_W   = 24;
    localparam int NUM_CHECKS = 11;
    localparam int PADDR_W    = 2;
    localparam int PDATA_W    = 32;

    // Chunk identifiers as they read in a little-endian word
    localparam logic [WORD_W-1:0] ID_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] ID_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] ID_DATA = 32'h6174_6164;

    localparam logic [WORD_W-1:0] FMT_SIZE_PCM  = 32'd16;
    localparam logic [15:0]       FORMAT_PCM    = 16'd1;
    localparam logic [15:0]       CHANNELS_MONO = 16'd1;
    localparam logic [15:0]       BITS_16       = 16'd16;
    localparam logic [15:0]       ALIGN_MONO16  = 16'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

    // Header byte index of the last byte of each checked word
    localparam logic [POS_W-1:0] POS_RIFF      = 6'd3;
    localparam logic [POS_W-1:0] POS_WAVE      = 6'd11;
    localparam logic [POS_W-1:0] POS_FMT_ID    = 6'd15;
    localparam logic [POS_W-1:0] POS_FMT_SIZE  = 6'd19;
    localparam logic [POS_W-1:0] POS_FORMAT    = 6'd23;
    localparam logic [POS_W-1:0] POS_RATE      = 6'd27;
    localparam logic [POS_W-1:0] POS_AVG_BPS   = 6'd31;
    localparam logic [POS_W-1:0] POS_ALIGN     = 6'd35;
    localparam logic [POS_W-1:0] POS_DATA_ID   = 6'd39;
    localparam logic [POS_W-1:0] POS_DATA_SIZE = 6'd43;

    localparam logic [PADDR_W-1:0] ADDR_RATE = 2'd0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_RIFF      = 4'd1,
        ERR_WAVE      = 4'd2,
        ERR_FMT_ID    = 4'd3,
        ERR_FMT_SIZE  = 4'd4,
        ERR_FORMAT    = 4'd5,
        ERR_CHANNELS  = 4'd6,
        ERR_RATE      = 4'd7,
        ERR_BITS      = 4'd8,
        ERR_AVG_BPS   = 4'd9,
        ERR_ALIGN     = 4'd10,
        ERR_DATA_ID   = 4'd11
    } t_err;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        t_err                  err;
        logic [SAMPLE_W-1:0]   sample;
        logic                  last;
    } t_result;

    // Failure flag for a check: bit k stands for error code k+1
    function automatic logic [NUM_CHECKS-1:0] chk_bit(input t_err e);
        return NUM_CHECKS'(1) << (4'(e) - 4'd1);
    endfunction

    // Lowest set flag wins
    function automatic t_err first_error(input logic [NUM_CHECKS-1:0] f);
        t_err e;
        e = ERR_OK;
        for (int k = NUM_CHECKS - 1; k >= 0; k--) begin
            if (f[k]) begin
                e = t_err'(4'(k + 1));
            end
        end
        return e;
    endfunction

endpackage

@@ design/whc_if.sv @@
// ----------------------------------------------------------------------------
// whc_in_if / whc_out_if
// Valid/ready channels for raw file bytes and for results.
// ----------------------------------------------------------------------------
interface whc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface whc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [3:0]  error_code;
    logic [23:0] sample_word;
    logic        last_sample;

    modport source (output valid, output result_kind, output error_code,
                    output sample_word, output last_sample, input ready);
    modport sink   (input valid, input result_kind, input error_code,
                    input sample_word, input last_sample, output ready);
endinterface

@@ design/whc_parser.sv @@
// ----------------------------------------------------------------------------
// whc_parser
// Per-byte header checker and sample pairing; updates its state on i_fire.
// ----------------------------------------------------------------------------
module whc_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [whc_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_first_byte,
    input  logic [whc_pkg::RATE_W-1:0]  i_expected_rate,
    output logic                        o_res_valid,
    output whc_pkg::t_result            o_result
);
    import whc_pkg::*;

    logic [POS_W-1:0]      r_pos,    n_pos,    s_pos;
    t_phase                r_phase,  n_phase,  s_phase;
    logic [WORD_W-1:0]     r_asm,    n_asm,    s_asm;
    logic [NUM_CHECKS-1:0] r_fail,   n_fail,   s_fail;
    logic [WORD_W-1:0]     r_remain, n_remain, s_remain;
    logic [BYTE_W-1:0]     r_low,    n_low,    s_low;
    logic                  r_parity, n_parity, s_parity;
    logic                  w_status;
    logic                  w_sample;

    // Next state
    always_comb begin
        s_pos    = r_pos;
        s_phase  = r_phase;
        s_asm    = r_asm;
        s_fail   = r_fail;
        s_remain = r_remain;
        s_low    = r_low;
        s_parity = r_parity;
        if (i_first_byte) begin
            s_pos    = '0;
            s_phase  = PH_HEAD;
            s_asm    = '0;
            s_fail   = '0;
            s_remain = '0;
            s_low    = '0;
            s_parity = 1'b0;
        end

        n_pos    = s_pos;
        n_phase  = s_phase;
        n_asm    = s_asm;
        n_fail   = s_fail;
        n_remain = s_remain;
        n_low    = s_low;
        n_parity = s_parity;
        w_status = 1'b0;
        w_sample = 1'b0;

        unique case (s_phase)
            PH_HEAD: begin
                n_asm = {i_data_byte, s_asm[WORD_W-1:BYTE_W]};
                n_pos = s_pos + POS_W'(1);
                unique case (s_pos)
                    POS_RIFF: begin
                        if (n_asm != ID_RIFF) n_fail = n_fail | chk_bit(ERR_RIFF);
                    end
                    POS_WAVE: begin
                        if (n_asm != ID_WAVE) n_fail = n_fail | chk_bit(ERR_WAVE);
                    end
                    POS_FMT_ID: begin
                        if (n_asm != ID_FMT) n_fail = n_fail | chk_bit(ERR_FMT_ID);
                    end
                    POS_FMT_SIZE: begin
                        if (n_asm != FMT_SIZE_PCM) n_fail = n_fail | chk_bit(ERR_FMT_SIZE);
                    end
                    POS_FORMAT: begin
                        if (n_asm[15:0] != FORMAT_PCM) n_fail = n_fail | chk_bit(ERR_FORMAT);
                        if (n_asm[31:16] != CHANNELS_MONO) begin
                            n_fail = n_fail | chk_bit(ERR_CHANNELS);
                        end
                    end
                    POS_RATE: begin
                        if (n_asm != {{(WORD_W-RATE_W){1'b0}}, i_expected_rate}) begin
                            n_fail = n_fail | chk_bit(ERR_RATE);
                        end
                    end
                    POS_AVG_BPS: begin
                        // Low 32 bits of the bytes-per-second field times 8 against rate*16
                        if ({n_asm[WORD_W-4:0], 3'b000} !=
                            {{(WORD_W-RATE_W-4){1'b0}}, i_expected_rate, 4'b0000}) begin
                            n_fail = n_fail | chk_bit(ERR_AVG_BPS);
                        end
                    end
                    POS_ALIGN: begin
                        if (n_asm[15:0] != ALIGN_MONO16) n_fail = n_fail | chk_bit(ERR_ALIGN);
                        if (n_asm[31:16] != BITS_16) n_fail = n_fail | chk_bit(ERR_BITS);
                    end
                    POS_DATA_ID: begin
                        if (n_asm != ID_DATA) n_fail = n_fail | chk_bit(ERR_DATA_ID);
                    end
                    POS_DATA_SIZE: begin
                        w_status = 1'b1;
                        n_pos    = '0;
                        if (n_fail == '0 && n_asm[WORD_W-1:1] != '0) begin
                            n_phase  = PH_DATA;
                            n_remain = n_asm;
                            n_parity = 1'b0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            PH_DATA: begin
                if (!s_parity) begin
                    n_low    = i_data_byte;
                    n_parity = 1'b1;
                end else begin
                    n_parity = 1'b0;
                    n_remain = s_remain - WORD_W'(2);
                    w_sample = 1'b1;
                    if (n_remain[WORD_W-1:1] == '0) n_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // Result
    always_comb begin
        o_res_valid     = i_fire && (w_status || w_sample);
        o_result.kind   = w_sample ? KIND_SAMPLE : KIND_STATUS;
        o_result.err    = w_status ? first_error(n_fail) : ERR_OK;
        o_result.sample = w_sample ? {i_data_byte, s_low, 8'h00} : '0;
        o_result.last   = w_sample && (n_remain[WORD_W-1:1] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= PH_IDLE;
            r_asm    <= '0;
            r_fail   <= '0;
            r_remain <= '0;
            r_low    <= '0;
            r_parity <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_asm    <= n_asm;
            r_fail   <= n_fail;
            r_remain <= n_remain;
            r_low    <= n_low;
            r_parity <= n_parity;
        end
    end

endmodule

@@ design/wav_header_check_sample_unpacker_core.sv @@
// ----------------------------------------------------------------------------
// wav_header_check_sample_unpacker_core
// WAV (RIFF, PCM, 16-bit mono) header checker and sample unpacker.
// ----------------------------------------------------------------------------
// The block takes a WAV file one byte per transaction on i_in; first_byte
// restarts parsing at header byte 0. After the 44th header byte it returns one
// status transaction (error_code 0, or the failed check with the lowest error
// code), and after a good header it returns one sample transaction per byte
// pair of the data chunk, 16-bit little-endian shifted left by 8, with
// last_sample on the final pair; a trailing odd byte is dropped. It takes one
// byte per clock while the output is not stalled: an accepted byte lands in
// the input register, and when the parser fires it updates its counters and
// checks from that register while the result is loaded into the output
// register. A waiting result stalls the parser; the input register can still
// take one byte, and input ready drops only while both registers are full and
// the result is not taken.
// The expected sample rate is written through the APB port at address 0; the
// user must write it only while the block is idle, which the block itself
// does not enforce; it resets to 44100.
// ----------------------------------------------------------------------------
module wav_header_check_sample_unpacker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    whc_in_if.sink                        i_in,
    whc_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [whc_pkg::PADDR_W-1:0]   paddr,
    input  logic [whc_pkg::PDATA_W-1:0]   pwdata,
    output logic [whc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import whc_pkg::*;

    logic [RATE_W-1:0] r_rate;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_fire;
    logic              w_res_valid;
    t_result           w_result;

    // Configuration: always ready, write on the access cycle
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RATE) ? {{(PDATA_W-RATE_W){1'b0}}, r_rate} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_RATE) begin
            r_rate <= pwdata[RATE_W-1:0];
        end
    end

    // Advance the held byte whenever the output slot is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Hold the payload until the parser takes it
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    whc_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_data_byte     (r_in_byte),
        .i_first_byte    (r_in_first),
        .i_expected_rate (r_rate),
        .o_res_valid     (w_res_valid),
        .o_result        (w_result)
    );

    // Result register: load a new result, or drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out.kind;
    assign o_out.error_code  = r_out.err;
    assign o_out.sample_word = r_out.sample;
    assign o_out.last_sample = r_out.last;

endmodule
